@@ rtl/core/flow_table_retransmit_tracker_macros.svh @@
// assertion helpers for the flow table tracker
`ifndef FLOW_TABLE_RETRANSMIT_TRACKER_MACROS_SVH
`define FLOW_TABLE_RETRANSMIT_TRACKER_MACROS_SVH

`define FTRT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define FTRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ftrt_pkg.sv @@
`default_nettype none
package ftrt_pkg;
   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;
   localparam logic [16:0] HDR_V4     = 17'd34;
   localparam logic [16:0] HDR_V6     = 17'd54;

   typedef enum logic [1:0] {
      ST_UNTRACKED = 2'd0,
      ST_HIT       = 2'd1,
      ST_NEW       = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CMP,
      S_UPDATE,
      S_DONE
   } state_type;

   // key as stored in the table
   typedef struct packed {
      logic [63:0] src_hi;
      logic [63:0] src_lo;
      logic [63:0] dst_hi;
      logic [63:0] dst_lo;
      logic [31:0] ports;
      logic        is_v6;
   } key_type;

   typedef struct packed {
      logic [31:0] last_seq;
      logic [31:0] retrans;
   } flow_data_type;
endpackage
`default_nettype wire

@@ rtl/core/flow_table_retransmit_tracker.sv @@
// channel   | ports                       | direction | handshake
// request   | req_*, start, busy          | in        | start && !busy
// response  | rsp_*, rsp_valid            | out       | rsp_valid, one cycle
//
// untracked frames go through the done state to the response; a lookup reads and
// compares each entry in turn, then goes through update and done on a hit, or a
// last read, update and done on a miss. reset is synchronous and clears totals and
// the fill count; the table memories are covered by the fill count, no clearing pass.
// the response cannot be stalled; busy is high from acceptance until the response
// cycle, so the next request can be taken at the edge that ends the response.
`default_nettype none
`include "flow_table_retransmit_tracker_macros.svh"
module flow_table_retransmit_tracker
   import ftrt_pkg::*;
#(
   parameter int FLOW_ENTRIES = 64,
   parameter int COUNTER_BITS = 48
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_eth_type,
   input  wire logic [7:0]  req_ip_protocol,
   input  wire logic [63:0] req_src_addr_hi,
   input  wire logic [63:0] req_src_addr_lo,
   input  wire logic [63:0] req_dst_addr_hi,
   input  wire logic [63:0] req_dst_addr_lo,
   input  wire logic [15:0] req_src_port,
   input  wire logic [15:0] req_dst_port,
   input  wire logic [31:0] req_seq_number,
   input  wire logic [15:0] req_frame_length,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [5:0]       rsp_flow_index,
   output logic             rsp_retransmit,
   output logic [31:0]      rsp_flow_retransmissions,
   output logic [47:0]      rsp_total_packets,
   output logic [47:0]      rsp_tcp_packets,
   output logic [47:0]      rsp_tcp_bytes,
   output logic [47:0]      rsp_udp_packets,
   output logic [47:0]      rsp_udp_bytes,
   output logic [6:0]       rsp_flow_count
);
   localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int CW = $clog2(FLOW_ENTRIES + 1);

   key_type       key_mem [FLOW_ENTRIES];
   flow_data_type data_mem [FLOW_ENTRIES];

   state_type state_ff, state_in;
   key_type   key_ff, key_rd_ff;
   flow_data_type data_rd_ff;
   logic      tcp_ff, tracked_ff;
   logic [31:0] seq_ff;
   logic [CW-1:0] idx_ff, idx_in, count_ff;
   logic [COUNTER_BITS-1:0] pkt_ff, tpkt_ff, tbyte_ff, upkt_ff, ubyte_ff;
   logic [1:0]  st_ff;
   logic        retx_ff;
   logic [31:0] fretx_ff;
   logic        hit;

   logic is_v4, is_v6, is_l4, acc;
   logic [16:0] hdr, flen;
   logic [15:0] bytes;
   assign acc   = start && !busy;
   assign is_v4 = req_eth_type == ETYPE_IPV4;
   assign is_v6 = req_eth_type == ETYPE_IPV6;
   assign is_l4 = (is_v4 || is_v6) &&
                  (req_ip_protocol == PROTO_TCP || req_ip_protocol == PROTO_UDP);
   assign hdr   = is_v6 ? HDR_V6 : HDR_V4;
   assign flen  = {1'b0, req_frame_length};
   assign bytes = (flen > hdr) ? 16'(flen - hdr) : 16'd0;
   assign busy  = state_ff != S_IDLE;
   assign hit   = key_rd_ff == key_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (acc) state_in = is_l4 ? S_READ : S_DONE;
         S_READ:   state_in = (idx_ff == count_ff) ? S_UPDATE : S_CMP;
         S_CMP:    state_in = hit ? S_UPDATE : S_READ;
         S_UPDATE: state_in = S_DONE;
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      unique case (state_ff)
         S_IDLE:  idx_in = '0;
         S_CMP:   if (!hit) idx_in = idx_ff + 1'b1;
         default: idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pkt_ff   <= '0;
         tpkt_ff  <= '0;
         tbyte_ff <= '0;
         upkt_ff  <= '0;
         ubyte_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= state_ff == S_DONE;
         if (acc) begin
            pkt_ff <= pkt_ff + 1'b1;
            if (is_l4 && req_ip_protocol == PROTO_TCP) begin
               tpkt_ff  <= tpkt_ff + 1'b1;
               tbyte_ff <= tbyte_ff + COUNTER_BITS'(bytes);
            end else if (is_l4) begin
               upkt_ff  <= upkt_ff + 1'b1;
               ubyte_ff <= ubyte_ff + COUNTER_BITS'(bytes);
            end
         end
         if (state_ff == S_UPDATE && !(hit && idx_ff != count_ff) &&
             count_ff != CW'(FLOW_ENTRIES))
            count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (acc) begin
         key_ff.src_hi <= is_v6 ? req_src_addr_hi : 64'd0;
         key_ff.src_lo <= is_v6 ? req_src_addr_lo : {32'd0, req_src_addr_lo[31:0]};
         key_ff.dst_hi <= is_v6 ? req_dst_addr_hi : 64'd0;
         key_ff.dst_lo <= is_v6 ? req_dst_addr_lo : {32'd0, req_dst_addr_lo[31:0]};
         key_ff.ports  <= {req_src_port, req_dst_port};
         key_ff.is_v6  <= is_v6;
         tcp_ff   <= req_ip_protocol == PROTO_TCP;
         tracked_ff <= is_l4;
         seq_ff   <= req_seq_number;
      end
   end

   // one synchronous read port per memory
   always_ff @(posedge clock) begin
      if (state_ff == S_READ && idx_ff != count_ff) begin
         key_rd_ff  <= key_mem[idx_ff[IW-1:0]];
         data_rd_ff <= data_mem[idx_ff[IW-1:0]];
      end
   end

   // read-modify-write; only one entry in flight so no forwarding needed
   always_ff @(posedge clock) begin
      if (state_ff == S_UPDATE) begin
         if (idx_ff != count_ff) begin
            if (tcp_ff) begin
               if (data_rd_ff.last_seq <= seq_ff)
                  data_mem[idx_ff[IW-1:0]].last_seq <= seq_ff;
               else if (data_rd_ff.retrans != 32'hFFFF_FFFF)
                  data_mem[idx_ff[IW-1:0]].retrans <= data_rd_ff.retrans + 1'b1;
            end
         end else if (count_ff != CW'(FLOW_ENTRIES)) begin
            key_mem[idx_ff[IW-1:0]]  <= key_ff;
            data_mem[idx_ff[IW-1:0]] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         st_ff    <= ST_UNTRACKED;
         retx_ff  <= 1'b0;
         fretx_ff <= '0;
      end
      if (state_ff == S_UPDATE) begin
         if (idx_ff != count_ff) begin
            st_ff <= ST_HIT;
            if (tcp_ff && data_rd_ff.last_seq > seq_ff) begin
               retx_ff  <= 1'b1;
               fretx_ff <= (data_rd_ff.retrans != 32'hFFFF_FFFF) ?
                           data_rd_ff.retrans + 1'b1 : data_rd_ff.retrans;
            end else
               fretx_ff <= data_rd_ff.retrans;
         end else if (count_ff != CW'(FLOW_ENTRIES))
            st_ff <= ST_NEW;
         else
            st_ff <= ST_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE) begin
         rsp_status               <= st_ff;
         rsp_flow_index           <= (st_ff == ST_HIT || st_ff == ST_NEW) ?
                                     6'(idx_ff) : 6'd0;
         rsp_retransmit           <= retx_ff;
         rsp_flow_retransmissions <= fretx_ff;
         rsp_total_packets        <= 48'(pkt_ff);
         rsp_tcp_packets          <= 48'(tpkt_ff);
         rsp_tcp_bytes            <= 48'(tbyte_ff);
         rsp_udp_packets          <= 48'(upkt_ff);
         rsp_udp_bytes            <= 48'(ubyte_ff);
         rsp_flow_count           <= 7'(count_ff);
      end
   end

   `FTRT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(FLOW_ENTRIES), "count overflow")
   `FTRT_ASSERT_NEXT(a_done_valid, clock, reset, state_ff == S_DONE, rsp_valid, "missing response")
   `FTRT_ASSERT_IMP(a_busy_valid, clock, reset, rsp_valid, !$past(acc), "response too early")
   `FTRT_ASSERT_IMP(a_untracked, clock, reset, state_ff == S_DONE && !tracked_ff, st_ff == ST_UNTRACKED, "untracked status")
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none
module testbench;
   import ftrt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS = 64;
   localparam int KEY_POOL = 80;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      logic [15:0] eth_type;
      logic [7:0]  ip_protocol;
      logic [63:0] src_hi;
      logic [63:0] src_lo;
      logic [63:0] dst_hi;
      logic [63:0] dst_lo;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] seq_number;
      logic [15:0] frame_length;
   } frame_type;

   typedef struct {
      status_type  status;
      logic [5:0]  flow_index;
      logic        retransmit;
      logic [31:0] flow_retrans;
      logic [47:0] total_packets;
      logic [47:0] tcp_packets;
      logic [47:0] tcp_bytes;
      logic [47:0] udp_packets;
      logic [47:0] udp_bytes;
      logic [6:0]  flow_count;
   } flow_result_type;

   class flow_scoreboard;
      key_type       flow_key[TABLE_SLOTS];
      flow_data_type flow_data[TABLE_SLOTS];
      int            occupied;
      logic [47:0]   pkt_total, tcp_pkts, tcp_bytes, udp_pkts, udp_bytes;
      flow_result_type pending_results[$];
      int            errors;

      function new();
         occupied = 0;
         pkt_total = '0;
         tcp_pkts = '0;
         tcp_bytes = '0;
         udp_pkts = '0;
         udp_bytes = '0;
         errors = 0;
      endfunction

      function void note_frame(frame_type f);
         flow_result_type r;
         key_type      k;
         logic         v6, tcp;
         logic [16:0]  hdr, nbytes;
         int           slot;
         r.status = ST_UNTRACKED;
         r.flow_index = '0;
         r.retransmit = 1'b0;
         r.flow_retrans = '0;
         pkt_total = pkt_total + 1;
         if ((f.eth_type == ETYPE_IPV4 || f.eth_type == ETYPE_IPV6) &&
             (f.ip_protocol == PROTO_TCP || f.ip_protocol == PROTO_UDP)) begin
            v6 = (f.eth_type == ETYPE_IPV6);
            tcp = (f.ip_protocol == PROTO_TCP);
            hdr = v6 ? HDR_V6 : HDR_V4;
            nbytes = ({1'b0, f.frame_length} > hdr) ? {1'b0, f.frame_length} - hdr : '0;
            k.src_hi = v6 ? f.src_hi : '0;
            k.dst_hi = v6 ? f.dst_hi : '0;
            k.src_lo = v6 ? f.src_lo : {32'd0, f.src_lo[31:0]};
            k.dst_lo = v6 ? f.dst_lo : {32'd0, f.dst_lo[31:0]};
            k.ports = {f.src_port, f.dst_port};
            k.is_v6 = v6;
            if (tcp) begin
               tcp_pkts = tcp_pkts + 1;
               tcp_bytes = tcp_bytes + nbytes;
            end else begin
               udp_pkts = udp_pkts + 1;
               udp_bytes = udp_bytes + nbytes;
            end
            slot = -1;
            for (int i = 0; i < occupied; i++)
               if (slot < 0 && flow_key[i] == k) slot = i;
            if (slot >= 0) begin
               if (tcp) begin
                  if (flow_data[slot].last_seq <= f.seq_number) begin
                     flow_data[slot].last_seq = f.seq_number;
                  end else begin
                     r.retransmit = 1'b1;
                     if (flow_data[slot].retrans != '1)
                        flow_data[slot].retrans = flow_data[slot].retrans + 1;
                  end
               end
               r.status = ST_HIT;
               r.flow_index = slot[5:0];
               r.flow_retrans = flow_data[slot].retrans;
            end else if (occupied < TABLE_SLOTS) begin
               flow_key[occupied] = k;
               flow_data[occupied] = '0;
               r.status = ST_NEW;
               r.flow_index = occupied[5:0];
               occupied++;
            end else begin
               r.status = ST_FULL;
            end
         end
         r.total_packets = pkt_total;
         r.tcp_packets = tcp_pkts;
         r.tcp_bytes = tcp_bytes;
         r.udp_packets = udp_pkts;
         r.udp_bytes = udp_bytes;
         r.flow_count = occupied[6:0];
         pending_results.push_back(r);
      endfunction

      function void compare(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(flow_result_type got);
         flow_result_type want;
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         want = pending_results.pop_front();
         compare("status", want.status, got.status);
         compare("flow_index", want.flow_index, got.flow_index);
         compare("retransmit", want.retransmit, got.retransmit);
         compare("flow_retransmissions", want.flow_retrans, got.flow_retrans);
         compare("total_packets", want.total_packets, got.total_packets);
         compare("tcp_packets", want.tcp_packets, got.tcp_packets);
         compare("tcp_bytes", want.tcp_bytes, got.tcp_bytes);
         compare("udp_packets", want.udp_packets, got.udp_packets);
         compare("udp_bytes", want.udp_bytes, got.udp_bytes);
         compare("flow_count", want.flow_count, got.flow_count);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_eth_type = '0;
   logic [7:0]  req_ip_protocol = '0;
   logic [63:0] req_src_addr_hi = '0, req_src_addr_lo = '0;
   logic [63:0] req_dst_addr_hi = '0, req_dst_addr_lo = '0;
   logic [15:0] req_src_port = '0, req_dst_port = '0;
   logic [31:0] req_seq_number = '0;
   logic [15:0] req_frame_length = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_flow_index;
   logic        rsp_retransmit;
   logic [31:0] rsp_flow_retransmissions;
   logic [47:0] rsp_total_packets, rsp_tcp_packets, rsp_tcp_bytes;
   logic [47:0] rsp_udp_packets, rsp_udp_bytes;
   logic [6:0]  rsp_flow_count;

   flow_table_retransmit_tracker dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_eth_type(req_eth_type), .req_ip_protocol(req_ip_protocol),
      .req_src_addr_hi(req_src_addr_hi), .req_src_addr_lo(req_src_addr_lo),
      .req_dst_addr_hi(req_dst_addr_hi), .req_dst_addr_lo(req_dst_addr_lo),
      .req_src_port(req_src_port), .req_dst_port(req_dst_port),
      .req_seq_number(req_seq_number), .req_frame_length(req_frame_length),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_flow_index(rsp_flow_index), .rsp_retransmit(rsp_retransmit),
      .rsp_flow_retransmissions(rsp_flow_retransmissions),
      .rsp_total_packets(rsp_total_packets), .rsp_tcp_packets(rsp_tcp_packets),
      .rsp_tcp_bytes(rsp_tcp_bytes), .rsp_udp_packets(rsp_udp_packets),
      .rsp_udp_bytes(rsp_udp_bytes), .rsp_flow_count(rsp_flow_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   flow_scoreboard scoreboard = new();
   int idle_pct = 0;
   int stall_cycles = 0;

   // key pool for the random part; more keys than slots so the table fills
   logic [63:0] pool_src_hi[KEY_POOL], pool_src_lo[KEY_POOL];
   logic [63:0] pool_dst_hi[KEY_POOL], pool_dst_lo[KEY_POOL];
   logic [15:0] pool_sport[KEY_POOL], pool_dport[KEY_POOL];
   logic        pool_v6[KEY_POOL];
   logic [31:0] pool_seq[KEY_POOL];

   always @(posedge clock) begin
      flow_result_type got;
      if (!reset && rsp_valid) begin
         got.status = status_type'(rsp_status);
         got.flow_index = rsp_flow_index;
         got.retransmit = rsp_retransmit;
         got.flow_retrans = rsp_flow_retransmissions;
         got.total_packets = rsp_total_packets;
         got.tcp_packets = rsp_tcp_packets;
         got.tcp_bytes = rsp_tcp_bytes;
         got.udp_packets = rsp_udp_packets;
         got.udp_bytes = rsp_udp_bytes;
         got.flow_count = rsp_flow_count;
         scoreboard.check_result(got);
      end
      if (reset || rsp_valid || (start && !busy)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_frame(frame_type f);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_eth_type <= f.eth_type;
      req_ip_protocol <= f.ip_protocol;
      req_src_addr_hi <= f.src_hi;
      req_src_addr_lo <= f.src_lo;
      req_dst_addr_hi <= f.dst_hi;
      req_dst_addr_lo <= f.dst_lo;
      req_src_port <= f.src_port;
      req_dst_port <= f.dst_port;
      req_seq_number <= f.seq_number;
      req_frame_length <= f.frame_length;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      scoreboard.note_frame(f);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic frame_type noise_frame();
      frame_type f;
      f.eth_type = 16'($urandom);
      f.ip_protocol = 8'($urandom);
      case ($urandom_range(3))
         0: f.eth_type = ETYPE_IPV4;
         1: f.eth_type = ETYPE_IPV6;
         default: ;
      endcase
      if ($urandom_range(1)) f.ip_protocol = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
      f.src_hi = rand64();
      f.src_lo = rand64();
      f.dst_hi = rand64();
      f.dst_lo = rand64();
      f.src_port = 16'($urandom);
      f.dst_port = 16'($urandom);
      f.seq_number = $urandom;
      f.frame_length = 16'($urandom);
      return f;
   endfunction

   function automatic frame_type pool_frame();
      frame_type f;
      int k;
      k = $urandom_range(KEY_POOL - 1);
      f = noise_frame();
      f.eth_type = pool_v6[k] ? ETYPE_IPV6 : ETYPE_IPV4;
      f.ip_protocol = ($urandom_range(3) != 0) ? PROTO_TCP : PROTO_UDP;
      f.src_lo = pool_src_lo[k];
      f.dst_lo = pool_dst_lo[k];
      // ipv4 keys get random upper bits, which must not matter
      if (pool_v6[k]) begin
         f.src_hi = pool_src_hi[k];
         f.dst_hi = pool_dst_hi[k];
      end else begin
         f.src_lo[63:32] = $urandom;
         f.dst_lo[63:32] = $urandom;
      end
      f.src_port = pool_sport[k];
      f.dst_port = pool_dport[k];
      case ($urandom_range(3))
         0: f.seq_number = pool_seq[k] - $urandom_range(1, 5000);
         1: f.seq_number = pool_seq[k];
         2: f.seq_number = pool_seq[k] + $urandom_range(0, 100000);
         default: f.seq_number = $urandom;
      endcase
      if (f.ip_protocol == PROTO_TCP && f.seq_number >= pool_seq[k])
         pool_seq[k] = f.seq_number;
      if ($urandom_range(7) == 0) f.frame_length = 16'($urandom_range(0, 60));
      return f;
   endfunction

   initial begin
      frame_type f, base;
      int phase_idle[3];
      phase_idle[0] = 19;
      phase_idle[1] = 77;
      phase_idle[2] = 0;
      for (int i = 0; i < KEY_POOL; i++) begin
         pool_v6[i] = 1'($urandom_range(1));
         pool_src_hi[i] = rand64();
         pool_src_lo[i] = rand64();
         pool_dst_hi[i] = rand64();
         pool_dst_lo[i] = rand64();
         pool_sport[i] = 16'($urandom);
         pool_dport[i] = 16'($urandom);
         pool_seq[i] = '0;
         // neighbors differing only in version or port
         if (i > 0 && $urandom_range(3) == 0) begin
            pool_src_hi[i] = pool_src_hi[i-1];
            pool_src_lo[i] = pool_src_lo[i-1];
            pool_dst_hi[i] = pool_dst_hi[i-1];
            pool_dst_lo[i] = pool_dst_lo[i-1];
            pool_sport[i] = pool_sport[i-1];
            if ($urandom_range(1)) pool_v6[i] = !pool_v6[i-1];
            else pool_dport[i] = 16'(pool_dport[i-1] + 1);
         end
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      f = noise_frame();
      f.eth_type = 16'hFFFF;
      f.ip_protocol = PROTO_TCP;
      send_frame(f);
      f.eth_type = ETYPE_IPV4;
      f.ip_protocol = 8'hFF;
      send_frame(f);
      base = noise_frame();
      base.eth_type = ETYPE_IPV4;
      base.ip_protocol = PROTO_TCP;
      base.seq_number = 32'd1000;
      base.frame_length = 16'hFFFF;
      send_frame(base);                        // new flow, seq not kept
      f = base;
      f.src_hi = rand64();
      f.dst_lo[63:32] = ~f.dst_lo[63:32];
      f.frame_length = 16'd0;
      send_frame(f);                           // hit, upper bits ignored
      f.seq_number = 32'd999;
      f.frame_length = 16'd34;
      send_frame(f);                           // retransmission
      f.seq_number = 32'd1000;
      f.frame_length = 16'd35;
      send_frame(f);                           // equal seq is fine
      f.seq_number = 32'hFFFFFFFF;
      send_frame(f);
      f.seq_number = 32'd0;
      send_frame(f);
      f.ip_protocol = PROTO_UDP;
      send_frame(f);                           // udp hit on tcp entry
      f = base;
      f.eth_type = ETYPE_IPV6;
      f.src_hi = '0;
      f.dst_hi = '0;
      f.src_lo[63:32] = '0;
      f.dst_lo[63:32] = '0;
      f.ip_protocol = PROTO_UDP;
      f.frame_length = 16'd54;
      send_frame(f);                           // same bits, other version
      f.ip_protocol = PROTO_TCP;
      f.seq_number = 32'd5;
      f.frame_length = 16'd55;
      send_frame(f);                           // tcp hit on udp entry
      f.seq_number = 32'd4;
      send_frame(f);
      f = noise_frame();
      f.eth_type = ETYPE_IPV6;
      f.ip_protocol = PROTO_UDP;
      f.src_hi = '1;
      f.src_lo = '1;
      f.dst_hi = '1;
      f.dst_lo = '1;
      f.src_port = '1;
      f.dst_port = '1;
      f.frame_length = 16'hFFFF;
      send_frame(f);
      f.src_port = '0;
      f.dst_port = '0;
      f.frame_length = 16'd10;
      send_frame(f);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = phase_idle[phase];
         for (int n = 0; n < 450; n++) begin
            if ($urandom_range(99) < 15) send_frame(noise_frame());
            else send_frame(pool_frame());
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (scoreboard.pending_results.size() != 0) @(posedge clock);
      repeat (140) @(posedge clock);
      if (scoreboard.errors == 0 && scoreboard.pending_results.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
